>>> src/tetx_pkg.sv
// Shared types, codes and constants of the tagged event time extractor.
package tetx_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_TIME_EVENT_ID = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_DAY_LIMIT     = 1'd1;

  localparam logic [7:0]  TimeEventIdReset = 8'd237;
  localparam logic [15:0] DayLimitReset    = 16'd3650;

  localparam logic [1:0] ST_BAD_HEADER = 2'd0;
  localparam logic [1:0] ST_NO_EVENT   = 2'd1;
  localparam logic [1:0] ST_NO_VALUE   = 2'd2;
  localparam logic [1:0] ST_FOUND      = 2'd3;

  // first tag byte in the lowest bits
  localparam logic [31:0] TagHead = 32'h6468_4C46;
  localparam logic [31:0] TagData = 32'h7464_4C46;

  typedef struct packed {
    logic        chunk_v;
    logic [63:0] chunk;
    logic        emit_v;
    logic        emit_time;
    logic [1:0]  emit_status;
    logic        restart;
  } tetx_parse_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        zero;
    logic [52:0] mant;
    logic [5:0]  shift;
  } tetx_req_t;

endpackage

>>> src/tetx_parser.sv
// Byte parser: header checks, event walk and time payload assembly.
module tetx_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           time_event_id_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_i,
  input  logic                 last_i,
  output logic                 item_valid_o,
  input  logic                 item_ready_i,
  output tetx_pkg::tetx_parse_t item_o
);
  import tetx_pkg::*;

  localparam logic [3:0] PhTag1   = 4'd0;
  localparam logic [3:0] PhHlen   = 4'd1;
  localparam logic [3:0] PhHskip  = 4'd2;
  localparam logic [3:0] PhTag2   = 4'd3;
  localparam logic [3:0] PhPad    = 4'd4;
  localparam logic [3:0] PhEvid   = 4'd5;
  localparam logic [3:0] PhEvlen  = 4'd6;
  localparam logic [3:0] PhEvskip = 4'd7;
  localparam logic [3:0] PhTime   = 4'd8;
  localparam logic [3:0] PhBad    = 4'd9;
  localparam logic [3:0] PhDone   = 4'd10;

  logic [3:0]  phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] skip_q, skip_d;
  logic [7:0]  id_q, id_d;
  logic [31:0] plen_q, plen_d;
  logic [5:0]  vshift_q, vshift_d;
  logic [63:0] asm_q, asm_d;
  logic        item_v_q;
  tetx_parse_t item_q, item_d;

  logic        bp_go;
  logic [31:0] bp_len;
  logic [7:0]  bp_id;
  logic [39:0] vint;
  logic        acc;

  assign in_ready_o   = !item_v_q || item_ready_i;
  assign acc          = in_valid_i && in_ready_o;
  assign item_valid_o = item_v_q;
  assign item_o       = item_q;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    skip_d   = skip_q;
    id_d     = id_q;
    plen_d   = plen_q;
    vshift_d = vshift_q;
    asm_d    = asm_q;
    item_d   = '0;
    bp_go    = 1'b0;
    bp_len   = '0;
    bp_id    = id_q;
    vint     = '0;
    unique case (phase_q)
      PhTag1: begin
        if (data_i != TagHead[{cnt_q[1:0], 3'b000} +: 8]) begin
          phase_d = PhBad;
        end else begin
          cnt_d = cnt_q + 32'd1;
          if (cnt_q[1:0] == 2'd3) begin
            cnt_d   = '0;
            skip_d  = '0;
            phase_d = PhHlen;
          end
        end
      end
      PhHlen: begin
        skip_d = skip_q | ({24'd0, data_i} << {cnt_q[1:0], 3'b000});
        cnt_d  = cnt_q + 32'd1;
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d   = '0;
          phase_d = (skip_d == '0) ? PhTag2 : PhHskip;
        end
      end
      PhHskip: begin
        skip_d = skip_q - 32'd1;
        if (skip_d == '0) begin
          cnt_d   = '0;
          phase_d = PhTag2;
        end
      end
      PhTag2: begin
        if (data_i != TagData[{cnt_q[1:0], 3'b000} +: 8]) begin
          phase_d = PhBad;
        end else begin
          cnt_d = cnt_q + 32'd1;
          if (cnt_q[1:0] == 2'd3) begin
            cnt_d   = '0;
            phase_d = PhPad;
          end
        end
      end
      PhPad: begin
        cnt_d = cnt_q + 32'd1;
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d   = '0;
          phase_d = PhEvid;
        end
      end
      PhEvid: begin
        id_d  = data_i;
        bp_id = data_i;
        if (data_i < 8'd64) begin
          bp_go  = 1'b1;
          bp_len = 32'd1;
        end else if (data_i < 8'd128) begin
          bp_go  = 1'b1;
          bp_len = 32'd2;
        end else if (data_i < 8'd192) begin
          bp_go  = 1'b1;
          bp_len = 32'd4;
        end else begin
          plen_d   = '0;
          vshift_d = '0;
          phase_d  = PhEvlen;
        end
      end
      PhEvlen: begin
        if (data_i[6:0] != 7'd0) begin
          if (vshift_q >= 6'd32) begin
            plen_d = '1;
          end else begin
            vint   = {8'd0, plen_q} | ({33'd0, data_i[6:0]} << vshift_q[4:0]);
            plen_d = (vint[39:32] != 8'd0) ? '1 : vint[31:0];
          end
        end
        if (!data_i[7]) begin
          bp_go  = 1'b1;
          bp_len = plen_d;
        end else begin
          vshift_d = (vshift_q > 6'd56) ? 6'd63 : vshift_q + 6'd7;
        end
      end
      PhEvskip: begin
        skip_d = skip_q - 32'd1;
        if (skip_d == '0) begin
          phase_d = PhEvid;
        end
      end
      PhTime: begin
        asm_d = asm_q | ({56'd0, data_i} << {cnt_q[2:0], 3'b000});
        if (cnt_q[2:0] == 3'd7) begin
          item_d.chunk_v = 1'b1;
          item_d.chunk   = asm_d;
          asm_d          = '0;
        end
        cnt_d = cnt_q + 32'd1;
        if (({1'b0, cnt_q} + 33'd1) >= {1'b0, plen_q}) begin
          item_d.emit_v    = 1'b1;
          item_d.emit_time = 1'b1;
          phase_d          = PhDone;
        end
      end
      default: begin
      end
    endcase

    if (bp_go) begin
      plen_d = bp_len;
      cnt_d  = '0;
      asm_d  = '0;
      if (bp_id == time_event_id_i && bp_len >= 32'd8) begin
        phase_d = PhTime;
      end else if (bp_len == '0) begin
        phase_d = PhEvid;
      end else begin
        skip_d  = bp_len;
        phase_d = PhEvskip;
      end
    end

    if (last_i) begin
      if (!item_d.emit_v && phase_q != PhDone) begin
        item_d.emit_v      = 1'b1;
        item_d.emit_status = (phase_d >= PhEvid && phase_d <= PhTime) ?
                             ST_NO_EVENT : ST_BAD_HEADER;
      end
      item_d.restart = 1'b1;
      phase_d  = PhTag1;
      cnt_d    = '0;
      skip_d   = '0;
      id_d     = '0;
      plen_d   = '0;
      vshift_d = '0;
      asm_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhTag1;
      cnt_q    <= '0;
      skip_q   <= '0;
      id_q     <= '0;
      plen_q   <= '0;
      vshift_q <= '0;
      asm_q    <= '0;
      item_v_q <= 1'b0;
    end else begin
      if (item_ready_i) begin
        item_v_q <= 1'b0;
      end
      if (acc) begin
        phase_q  <= phase_d;
        cnt_q    <= cnt_d;
        skip_q   <= skip_d;
        id_q     <= id_d;
        plen_q   <= plen_d;
        vshift_q <= vshift_d;
        asm_q    <= asm_d;
        item_v_q <= item_d.chunk_v || item_d.emit_v || item_d.restart;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      item_q <= item_d;
    end
  end

  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && last_i |=> phase_q == PhTag1 && cnt_q == '0 && asm_q == '0)
    else $error("parser did not restart after the last byte");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> item_v_q)
    else $error("input stalled with an empty parser output");

  a_done_has_no_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && phase_q == PhDone |-> !item_d.chunk_v && !item_d.emit_v)
    else $error("activity after the result was sent");

endmodule

>>> src/tetx_eval.sv
// Candidate check of each assembled double and result request selection.
module tetx_eval (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [15:0]           day_limit_i,
  input  logic                  item_valid_i,
  output logic                  item_ready_o,
  input  tetx_pkg::tetx_parse_t item_i,
  output logic                  req_valid_o,
  input  logic                  req_ready_i,
  output tetx_pkg::tetx_req_t   req_o
);
  import tetx_pkg::*;

  logic [10:0] expo;
  logic [51:0] frac;
  logic [52:0] mant;
  logic [10:0] shift_w;
  logic        ok;
  logic        zero_time;
  logic        is_zero;
  logic        take;
  logic        found_now;
  logic        found_q;
  logic        best_zero_q;
  logic [52:0] best_mant_q;
  logic [5:0]  best_shift_q;
  logic        acc;
  logic        req_v_q;
  tetx_req_t   req_q, req_d;

  assign item_ready_o = !req_v_q || req_ready_i;
  assign acc          = item_valid_i && item_ready_o;
  assign req_valid_o  = req_v_q;
  assign req_o        = req_q;

  assign expo    = item_i.chunk[62:52];
  assign frac    = item_i.chunk[51:0];
  assign is_zero = (expo == 11'd0) && (frac == 52'd0);
  assign mant    = {(expo != 11'd0), frac};
  assign shift_w = 11'd1075 - expo;

  always_comb begin
    ok        = 1'b0;
    zero_time = 1'b0;
    priority if (expo == 11'h7FF) begin
      ok = 1'b0;
    end else if (is_zero) begin
      ok        = (day_limit_i != 16'd0);
      zero_time = 1'b1;
    end else if (item_i.chunk[63]) begin
      ok = 1'b0;
    end else if (expo == 11'd0) begin
      ok        = (day_limit_i != 16'd0);
      zero_time = 1'b1;
    end else if (expo >= 11'd1075) begin
      ok = 1'b0;
    end else if (shift_w >= 11'd64) begin
      ok        = (day_limit_i != 16'd0);
      zero_time = 1'b1;
    end else begin
      ok = (mant >> shift_w[5:0]) < {37'd0, day_limit_i};
    end
  end

  assign take      = item_i.chunk_v && ok;
  assign found_now = found_q || take;

  always_comb begin
    req_d = '0;
    if (item_i.emit_time) begin
      req_d.status = found_now ? ST_FOUND : ST_NO_VALUE;
    end else begin
      req_d.status = item_i.emit_status;
    end
    if (take) begin
      req_d.zero  = zero_time;
      req_d.mant  = mant;
      req_d.shift = shift_w[5:0];
    end else begin
      req_d.zero  = best_zero_q;
      req_d.mant  = best_mant_q;
      req_d.shift = best_shift_q;
    end
    if (req_d.status != ST_FOUND) begin
      req_d.zero = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      req_v_q <= 1'b0;
    end else begin
      if (req_ready_i) begin
        req_v_q <= 1'b0;
      end
      if (acc) begin
        found_q <= item_i.restart ? 1'b0 : found_now;
        if (item_i.emit_v) begin
          req_v_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && take) begin
      best_zero_q  <= zero_time;
      best_mant_q  <= mant;
      best_shift_q <= shift_w[5:0];
    end
    if (acc && item_i.emit_v) begin
      req_q <= req_d;
    end
  end

endmodule

>>> src/tetx_split.sv
// Hours and minutes from the accepted double, held in the output register.
module tetx_split (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  tetx_pkg::tetx_req_t req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [20:0]         hours_o,
  output logic [5:0]          minutes_o
);
  import tetx_pkg::*;

  logic [63:0] m64;
  logic [63:0] p24;
  logic [63:0] p1440;
  logic [63:0] hh;
  logic [63:0] tm;
  logic [20:0] hours_d;
  logic [5:0]  minutes_d;
  logic        out_v_q;
  logic [1:0]  status_q;
  logic [20:0] hours_q;
  logic [5:0]  minutes_q;
  logic        acc;

  assign req_ready_o = !out_v_q || out_ready_i;
  assign acc         = req_valid_i && req_ready_o;

  assign m64   = {11'd0, req_i.mant};
  assign p24   = (m64 << 4) + (m64 << 3);
  assign p1440 = (m64 << 10) + (m64 << 8) + (m64 << 7) + (m64 << 5);
  assign hh    = p24 >> req_i.shift;
  assign tm    = p1440 >> req_i.shift;

  // 60 is -4 modulo 64, so the minute remainder needs only the low bits
  always_comb begin
    if (req_i.zero) begin
      hours_d   = '0;
      minutes_d = '0;
    end else begin
      hours_d   = hh[20:0];
      minutes_d = tm[5:0] + {hh[3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (acc) begin
        out_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      status_q  <= req_i.status;
      hours_q   <= hours_d;
      minutes_q <= minutes_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign status_o    = status_q;
  assign hours_o     = hours_q;
  assign minutes_o   = minutes_q;

endmodule

>>> src/tagged_event_time_extractor_top.sv
// Top level of the tagged event time extractor: config registers and stage chain.
//
//  channel  direction  payload
//  s_axis   in         tdata[7:0] file byte, tlast final byte of the file
//  m_axis   out        tdata hours/minutes, tuser status
//  cfg      in         cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
//  One byte is accepted every cycle while results are taken.
//  A result reaches the output from the edge that accepts its byte through three registers
//  (parser register, candidate register, output register).
//  Reset clears parser state and both configuration registers to their defaults.
//  A stalled output holds its result; each stage keeps taking work while the next has room.
module tagged_event_time_extractor_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] data_byte
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [31:0]                  m_axis_tdata,   // [20:0] hours, [26:21] minutes
  output logic [1:0]                   m_axis_tuser,   // [1:0] status
  input  logic                         cfg_we_i,
  input  logic [tetx_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tetx_pkg::CfgDataW-1:0] cfg_data_i
);
  import tetx_pkg::*;

  logic [7:0]  time_event_id_q;
  logic [15:0] day_limit_q;

  tetx_parse_t item;
  logic        item_valid;
  logic        item_ready;
  tetx_req_t   req;
  logic        req_valid;
  logic        req_ready;
  logic [1:0]  status;
  logic [20:0] hours;
  logic [5:0]  minutes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_event_id_q <= TimeEventIdReset;
      day_limit_q     <= DayLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TIME_EVENT_ID: time_event_id_q <= cfg_data_i[7:0];
        CFG_DAY_LIMIT:     day_limit_q     <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  tetx_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .time_event_id_i (time_event_id_q),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .data_i          (s_axis_tdata),
    .last_i          (s_axis_tlast),
    .item_valid_o    (item_valid),
    .item_ready_i    (item_ready),
    .item_o          (item)
  );

  tetx_eval u_eval (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .day_limit_i  (day_limit_q),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .req_valid_o  (req_valid),
    .req_ready_i  (req_ready),
    .req_o        (req)
  );

  tetx_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .hours_o     (hours),
    .minutes_o   (minutes)
  );

  assign m_axis_tdata = {5'd0, minutes, hours};
  assign m_axis_tuser = status;

  a_minutes_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[26:21] < 6'd60)
    else $error("minutes out of range");

  a_zero_unless_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_FOUND |-> m_axis_tdata[26:0] == 27'd0)
    else $error("time fields set without a found time");

  a_hours_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[20:0] < 21'd1572840)
    else $error("hours beyond the largest day limit");

endmodule
